// ===== rtl/ffba_pkg.sv =====
// shared types and constants of the first-fit block allocator
// no dependencies; used by the interfaces and the top level

package ffba_pkg;

  localparam int OffsetW = 12;
  localparam int LengthW = 13;
  localparam int StatusW = 2;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } ffba_op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK         = 2'd0,
    ST_NO_GAP     = 2'd1,
    ST_TABLE_FULL = 2'd2,
    ST_NOT_FOUND  = 2'd3
  } ffba_status_e;

endpackage

// ===== rtl/ffba_if.sv =====
// request and response channel interfaces of the first-fit block allocator
// depends on ffba_pkg

interface ffba_req_if import ffba_pkg::*; ();
  logic                 valid;
  logic                 ready;
  ffba_op_e             operation;
  logic [LengthW-1:0]   request_length;
  logic [OffsetW-1:0]   block_offset;

  modport source (output valid, operation, request_length, block_offset, input ready);
  modport sink   (input valid, operation, request_length, block_offset, output ready);
endinterface

interface ffba_rsp_if import ffba_pkg::*; ();
  logic                 valid;
  logic                 ready;
  ffba_status_e         status;
  logic [OffsetW-1:0]   granted_offset;

  modport source (output valid, status, granted_offset, input ready);
  modport sink   (input valid, status, granted_offset, output ready);
endinterface

// ===== rtl/first_fit_block_allocator_unit.sv =====
// first-fit block allocator: descriptor table in a single-port-write, registered-read memory,
// walked one descriptor per cycle. A request (allocate or free) is taken only while the unit
// is idle. A free or an allocate that finds no gap answers from the walk; an allocate that fits
// goes on to place the block, and then to link its predecessor unless it becomes the new head,
// and a zero-length allocate answers without a walk. Allocate also needs the lowest unused slot,
// which a counter finds over the used bits in parallel with the walk, so an allocate that fits
// never answers before that counter reaches the slot or the end of the table. The unit returns
// to idle before the next acceptance; the walk is bounded by the one memory read per cycle. A
// finished response sits in an output register, and a new request is accepted while it waits.
// Depends on ffba_pkg and ffba_if.

module first_fit_block_allocator_unit import ffba_pkg::*; #(
  parameter int ARENA_BYTES = 4096,
  parameter int SLOT_COUNT  = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ffba_req_if.sink    req_i,
  ffba_rsp_if.source  rsp_o
);

  localparam int IdxW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int LinkW = $clog2(SLOT_COUNT + 1);
  localparam int EndW  = LengthW + 1;
  localparam int SumW  = ($clog2(ARENA_BYTES + 1) > EndW + 1) ? $clog2(ARENA_BYTES + 1) : EndW + 1;

  localparam logic [LinkW-1:0] NullLink = LinkW'(SLOT_COUNT);
  localparam logic [SumW-1:0]  ArenaEnd = SumW'(ARENA_BYTES);

  typedef struct packed {
    logic [OffsetW-1:0] start;
    logic [LengthW-1:0] length;
    logic [LinkW-1:0]   link;
  } slot_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_WALK = 5'b00010,
    S_FIT  = 5'b00100,
    S_LINK = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // descriptor memory
  slot_t            slot_mem [SLOT_COUNT];
  slot_t            rd_data_q;
  logic [IdxW-1:0]  rd_addr;
  logic             wr_en;
  logic [IdxW-1:0]  wr_addr;
  slot_t            wr_data;

  logic [SLOT_COUNT-1:0] used_q, used_d;
  logic [LinkW-1:0]      head_q, head_d;

  // request context
  ffba_op_e            op_q, op_d;
  logic [LengthW-1:0]  len_q, len_d;
  logic [OffsetW-1:0]  offset_q, offset_d;
  logic [LinkW-1:0]    cur_q, cur_d;
  logic [LinkW-1:0]    prev_q, prev_d;
  logic [OffsetW-1:0]  prev_st_q, prev_st_d;
  logic [LengthW-1:0]  prev_len_q, prev_len_d;
  logic [EndW-1:0]     prev_end_q, prev_end_d;
  logic [LinkW-1:0]    fresh_q, fresh_d;
  ffba_status_e        status_q, status_d;

  // response register
  logic                out_valid_q, out_valid_d;
  ffba_status_e        out_status_q, out_status_d;
  logic [OffsetW-1:0]  out_offset_q, out_offset_d;

  logic            req_fire;
  logic            cur_ok, nxt_ok;
  logic [LinkW-1:0] nxt_link;
  logic [SumW-1:0] need_end;
  logic            gap_fits, tail_fits;
  logic [EndW-1:0] blk_end;
  logic            fresh_full, fresh_free, scan_done;

  function automatic logic link_ok(logic [LinkW-1:0] s, logic [SLOT_COUNT-1:0] used);
    return (s < NullLink) && used[s[IdxW-1:0]];
  endfunction

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_status_q;
  assign rsp_o.granted_offset = out_offset_q;

  assign cur_ok    = link_ok(cur_q, used_q);
  assign nxt_link  = link_ok(rd_data_q.link, used_q) ? rd_data_q.link : NullLink;
  assign nxt_ok    = (nxt_link != NullLink);
  assign need_end  = SumW'(prev_end_q) + SumW'(len_q);
  assign gap_fits  = SumW'(rd_data_q.start) >= need_end;
  assign tail_fits = need_end <= ArenaEnd;
  assign blk_end   = EndW'(rd_data_q.start) + EndW'(rd_data_q.length);

  assign fresh_full = (fresh_q == NullLink);
  assign fresh_free = !fresh_full && !used_q[fresh_q[IdxW-1:0]];
  assign scan_done  = fresh_full || fresh_free;

  always_comb begin
    state_d      = state_q;
    used_d       = used_q;
    head_d       = head_q;
    op_d         = op_q;
    len_d        = len_q;
    offset_d     = offset_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    prev_st_d    = prev_st_q;
    prev_len_d   = prev_len_q;
    prev_end_d   = prev_end_q;
    fresh_d      = fresh_q;
    status_d     = status_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_offset_d = out_offset_q;
    rd_addr      = head_q[IdxW-1:0];
    wr_en        = 1'b0;
    wr_addr      = prev_q[IdxW-1:0];
    wr_data      = '{start: prev_st_q, length: prev_len_q, link: fresh_q};

    // lowest unused slot search runs alongside the walk
    if ((state_q == S_WALK || state_q == S_FIT) && !scan_done) begin
      fresh_d = fresh_q + LinkW'(1);
    end

    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          op_d       = req_i.operation;
          len_d      = req_i.request_length;
          offset_d   = req_i.block_offset;
          cur_d      = head_q;
          prev_d     = NullLink;
          prev_end_d = '0;
          fresh_d    = '0;
          if (req_i.operation == OP_ALLOC && req_i.request_length == '0) begin
            status_d = ST_NO_GAP;
            state_d  = S_DONE;
          end else begin
            state_d = S_WALK;
          end
        end
      end

      S_WALK: begin
        if (cur_ok) begin
          if (op_q == OP_FREE && rd_data_q.start == offset_q) begin
            // unlink the matching block
            if (prev_q != NullLink) begin
              wr_en   = 1'b1;
              wr_data = '{start: prev_st_q, length: prev_len_q, link: nxt_link};
            end else begin
              head_d = nxt_link;
            end
            used_d[cur_q[IdxW-1:0]] = 1'b0;
            status_d = ST_OK;
            state_d  = S_DONE;
          end else if (op_q == OP_ALLOC && gap_fits) begin
            state_d = S_FIT;
          end else begin
            prev_d     = cur_q;
            prev_st_d  = rd_data_q.start;
            prev_len_d = rd_data_q.length;
            prev_end_d = blk_end;
            cur_d      = nxt_link;
            rd_addr    = nxt_link[IdxW-1:0];
            if (!nxt_ok) begin
              cur_d = NullLink;
            end
          end
        end else if (op_q == OP_FREE) begin
          status_d = ST_NOT_FOUND;
          state_d  = S_DONE;
        end else if (tail_fits) begin
          cur_d   = NullLink;
          state_d = S_FIT;
        end else begin
          status_d = ST_NO_GAP;
          state_d  = S_DONE;
        end
      end

      S_FIT: begin
        if (scan_done) begin
          if (fresh_full) begin
            status_d = ST_TABLE_FULL;
            state_d  = S_DONE;
          end else begin
            wr_en   = 1'b1;
            wr_addr = fresh_q[IdxW-1:0];
            wr_data = '{start: prev_end_q[OffsetW-1:0], length: len_q, link: cur_q};
            used_d[fresh_q[IdxW-1:0]] = 1'b1;
            status_d = ST_OK;
            if (prev_q != NullLink) begin
              state_d = S_LINK;
            end else begin
              head_d  = fresh_q;
              state_d = S_DONE;
            end
          end
        end
      end

      S_LINK: begin
        // point the predecessor at the new block
        wr_en   = 1'b1;
        state_d = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_offset_d = (op_q == OP_ALLOC && status_q == ST_OK) ?
                         prev_end_q[OffsetW-1:0] : '0;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
    rd_data_q <= slot_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      head_q      <= NullLink;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      head_q      <= head_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    len_q        <= len_d;
    offset_q     <= offset_d;
    cur_q        <= cur_d;
    prev_q       <= prev_d;
    prev_st_q    <= prev_st_d;
    prev_len_q   <= prev_len_d;
    prev_end_q   <= prev_end_d;
    fresh_q      <= fresh_d;
    status_q     <= status_d;
    out_status_q <= out_status_d;
    out_offset_q <= out_offset_d;
  end

endmodule
